// ----- design/mwe_pkg.sv -----
// ----------------------------------------------------------------------------
// mwe_pkg: shared types and constants for the microwire EEPROM read slave
// Pin bit positions, request codes, word map and the serial word lookup.
// ----------------------------------------------------------------------------
package mwe_pkg;

	// Pin byte bit positions
	localparam int unsigned PIN_DOUT = 0;
	localparam int unsigned PIN_DIN  = 1;
	localparam int unsigned PIN_CLK  = 2;
	localparam int unsigned PIN_SEL  = 3;
	localparam int unsigned PIN_PRG  = 7;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Serial framing: clocks skipped before the address, last address clock,
	// last data clock of a word
	localparam logic [3:0] ADDR_FIRST_BIT = 4'd3;
	localparam logic [3:0] ADDR_LAST_BIT  = 4'd11;
	localparam logic [3:0] DATA_LAST_BIT  = 4'd15;

	// Word map
	localparam logic [7:0]  ADDR_ID    = 8'd0;
	localparam logic [7:0]  ADDR_MAC0  = 8'd7;
	localparam logic [7:0]  ADDR_MAC1  = 8'd8;
	localparam logic [7:0]  ADDR_MAC2  = 8'd9;
	localparam logic [15:0] WORD_ID    = 16'h8129;

	localparam int unsigned MAC_W = 48;

	// One input transaction as held in the input register
	typedef struct packed {
		logic       req_type;
		logic [7:0] pin_byte;
	} in_item_t;

	// Word served at a given address
	function automatic logic [15:0] word_at(input logic [7:0] addr,
		input logic [MAC_W-1:0] mac);
		logic [15:0] w;
		case (addr)
			ADDR_ID:   w = WORD_ID;
			ADDR_MAC0: w = mac[15:0];
			ADDR_MAC1: w = mac[31:16];
			ADDR_MAC2: w = mac[47:32];
			default:   w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

// ----- design/mwe_in_stage.sv -----
// ----------------------------------------------------------------------------
// mwe_in_stage: input register
// Captures one transaction per cycle while it is empty or the core advances, and releases it when the core advances.
// ----------------------------------------------------------------------------
module mwe_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mwe_pkg::in_item_t in_item,
	output logic              item_valid,
	output mwe_pkg::in_item_t item,
	input  logic              advance
);

	logic              valid_s1;
	mwe_pkg::in_item_t item_s1;

	// Take a new transaction when the stage is empty or draining this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold payload, load on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- design/mwe_core.sv -----
// ----------------------------------------------------------------------------
// mwe_core: EEPROM serial state and result register
// Applies one pin transaction to the serial state and registers the pins.
// ----------------------------------------------------------------------------
module mwe_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  mwe_pkg::in_item_t          item,
	output logic                       advance,
	input  logic [mwe_pkg::MAC_W-1:0]  mac,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 pins_out
);

	logic        out_valid_q;
	logic [7:0]  pins_out_q;
	logic [7:0]  last_pins_q;
	logic [7:0]  word_addr_q;
	logic [15:0] shift_word_q;
	logic [3:0]  bit_count_q;
	logic        addr_done_q;

	logic [7:0]  last_pins_n;
	logic [7:0]  word_addr_n;
	logic [15:0] shift_word_n;
	logic [3:0]  bit_count_n;
	logic        addr_done_n;
	logic [7:0]  p;
	logic        rise;
	logic [3:0]  bit_idx;

	// Move the held transaction into the result register when it is free
	assign advance = item_valid && (!out_valid_q || out_ready);

	// Step logic for one pin transaction
	always_comb begin
		last_pins_n  = last_pins_q;
		word_addr_n  = word_addr_q;
		shift_word_n = shift_word_q;
		bit_count_n  = bit_count_q;
		addr_done_n  = addr_done_q;
		p            = item.pin_byte;
		rise         = 1'b0;
		bit_idx      = mwe_pkg::DATA_LAST_BIT - bit_count_q;
		if (item.req_type == mwe_pkg::REQ_WRITE) begin
			if (p[mwe_pkg::PIN_PRG]) begin
				rise = p[mwe_pkg::PIN_CLK] && !last_pins_q[mwe_pkg::PIN_CLK];
				if (rise) begin
					if (addr_done_q) begin
						// Data mode: load word on first clock, drive MSB first
						if (bit_count_q == 4'd0) begin
							shift_word_n = mwe_pkg::word_at(word_addr_q, mac);
						end
						p[mwe_pkg::PIN_DOUT] = shift_word_n[bit_idx];
						if (bit_count_q == mwe_pkg::DATA_LAST_BIT) begin
							bit_count_n = 4'd0;
							word_addr_n = word_addr_q + 8'd1;
						end else begin
							bit_count_n = bit_count_q + 4'd1;
						end
					end else begin
						// Address mode: skip start and opcode, shift in address
						if (bit_count_q >= mwe_pkg::ADDR_FIRST_BIT) begin
							word_addr_n = {word_addr_q[6:0], p[mwe_pkg::PIN_DIN]};
						end
						if (bit_count_q >= mwe_pkg::ADDR_LAST_BIT) begin
							bit_count_n = 4'd0;
							addr_done_n = 1'b1;
						end else begin
							bit_count_n = bit_count_q + 4'd1;
						end
					end
				end
				// Drop select: end the transfer
				if (!p[mwe_pkg::PIN_SEL]) begin
					addr_done_n = 1'b0;
					word_addr_n = 8'd0;
					bit_count_n = 4'd0;
				end
			end
			last_pins_n = p;
		end
	end

	// Advance the serial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pins_q  <= 8'd0;
			word_addr_q  <= 8'd0;
			shift_word_q <= 16'd0;
			bit_count_q  <= 4'd0;
			addr_done_q  <= 1'b0;
		end else if (advance) begin
			last_pins_q  <= last_pins_n;
			word_addr_q  <= word_addr_n;
			shift_word_q <= shift_word_n;
			bit_count_q  <= bit_count_n;
			addr_done_q  <= addr_done_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_out_q <= last_pins_n;
		end
	end

	assign out_valid = out_valid_q;
	assign pins_out  = pins_out_q;

endmodule

// ----- design/microwire_eeprom_read_slave.sv -----
// ----------------------------------------------------------------------------
// microwire_eeprom_read_slave: read-only 93C56-style serial EEPROM
// Answers a bit-banged pin register and serves the ID word and station MAC.
// ----------------------------------------------------------------------------
// Each pin transaction passes from acceptance through the input register, then
// through the step logic into the result register. A new transaction is
// accepted every cycle while results are taken; the serial state (address,
// bit counter, shift word) is updated once per transaction as it advances.
// The MAC register is written through the config channel, which is always
// ready.
module microwire_eeprom_read_slave (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic [7:0]                pin_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                pins_out,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mwe_pkg::MAC_W-1:0] cfg_data
);

	logic [mwe_pkg::MAC_W-1:0] mac_address_q;
	mwe_pkg::in_item_t         in_item;
	mwe_pkg::in_item_t         item;
	logic                      item_valid;
	logic                      advance;

	// Config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mac_address_q <= cfg_data;
		end
	end

	assign in_item = '{req_type: req_type, pin_byte: pin_byte};

	mwe_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance)
	);

	mwe_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.mac        (mac_address_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pins_out   (pins_out)
	);

endmodule

// ----- design/mwe_checker.sv -----
// ----------------------------------------------------------------------------
// mwe_checker: port-level checks for the EEPROM read slave
// Watches the handshakes on the top-level ports.
// ----------------------------------------------------------------------------
module mwe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pins_out,
	input logic       cfg_ready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pins_out))
		else $error("result changed while stalled");

	// Input stalls only when the result side is backed up
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with result side free");

	// An accepted transaction while no result is held shows a result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("result missing after accept");

	// Config channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel stalled");

endmodule

bind microwire_eeprom_read_slave mwe_checker u_mwe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pins_out  (pins_out),
	.cfg_ready (cfg_ready)
);

// ----- bench/tb_microwire_eeprom_read_slave.sv -----
// ----------------------------------------------------------------------------
// tb_microwire_eeprom_read_slave: regression bench for the EEPROM read slave
// Drives pin-register transactions through the valid/ready input channel,
// including full serial reads framed by chip-select. A local model of the
// pin register and serial engine predicts every returned pin byte, and each
// result is checked in order. The station MAC is rewritten between phases,
// and idling on both channels is varied from phase to phase.
// ----------------------------------------------------------------------------
module tb_microwire_eeprom_read_slave;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 6;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          req_type;
	logic [7:0]                    pin_byte;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    pins_out;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mwe_pkg::MAC_W-1:0]     cfg_data;

	// Local copy of the EEPROM state and the station MAC
	logic [mwe_pkg::MAC_W-1:0]     station_mac = '0;
	logic [7:0]                    pins_state  = '0;
	logic [7:0]                    word_ptr    = '0;
	logic [15:0]                   shift_reg   = '0;
	logic [3:0]                    bit_cnt     = '0;
	logic                          addr_locked = 1'b0;

	// Pin bytes still due on the result channel, oldest first
	logic [7:0]                    pin_readback_q[$];

	int                            send_idle_pct = 0;
	int                            recv_idle_pct = 0;
	int                            items_sent    = 0;
	int                            error_count   = 0;
	int                            cycle_count   = 0;

	microwire_eeprom_read_slave u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pin_byte  (pin_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pins_out  (pins_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result channel at the current rate
	always @(negedge clk) begin
		out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("microwire_eeprom_read_slave regression: fail");
			$finish;
		end
	end

	// Word served at a serial address
	function automatic logic [15:0] rom_word(input logic [7:0] a);
		if (a == mwe_pkg::ADDR_ID)
			return mwe_pkg::WORD_ID;
		if (a >= mwe_pkg::ADDR_MAC0 && a <= mwe_pkg::ADDR_MAC2)
			return station_mac[16*(a-mwe_pkg::ADDR_MAC0) +: 16];
		return 16'h0000;
	endfunction

	// Advance the local EEPROM by one pin transaction, return the pin byte read back
	function automatic logic [7:0] eeprom_pin_step(input logic req, input logic [7:0] pin);
		logic [7:0] p;
		p = pin;
		if (req == mwe_pkg::REQ_WRITE) begin
			if (p[mwe_pkg::PIN_PRG]) begin
				if (p[mwe_pkg::PIN_CLK] && !pins_state[mwe_pkg::PIN_CLK]) begin
					if (addr_locked) begin
						if (bit_cnt == 4'd0)
							shift_reg = rom_word(word_ptr);
						p[mwe_pkg::PIN_DOUT] = shift_reg[mwe_pkg::DATA_LAST_BIT - bit_cnt];
						if (bit_cnt >= mwe_pkg::DATA_LAST_BIT) begin
							bit_cnt  = 4'd0;
							word_ptr = word_ptr + 8'd1;
						end else begin
							bit_cnt = bit_cnt + 4'd1;
						end
					end else begin
						if (bit_cnt >= mwe_pkg::ADDR_FIRST_BIT)
							word_ptr = {word_ptr[6:0], p[mwe_pkg::PIN_DIN]};
						if (bit_cnt >= mwe_pkg::ADDR_LAST_BIT) begin
							bit_cnt     = 4'd0;
							addr_locked = 1'b1;
						end else begin
							bit_cnt = bit_cnt + 4'd1;
						end
					end
				end
				// Chip-select low ends the transfer
				if (!p[mwe_pkg::PIN_SEL]) begin
					addr_locked = 1'b0;
					word_ptr    = 8'd0;
					bit_cnt     = 4'd0;
				end
			end
			pins_state = p;
		end
		return pins_state;
	endfunction

	// Build a pin byte with the named bits set and the rest random
	function automatic logic [7:0] make_pins(input logic prg, input logic sel,
		input logic clk_bit, input logic din);
		logic [7:0] p;
		p = 8'($urandom);
		p[mwe_pkg::PIN_PRG] = prg;
		p[mwe_pkg::PIN_SEL] = sel;
		p[mwe_pkg::PIN_CLK] = clk_bit;
		p[mwe_pkg::PIN_DIN] = din;
		return p;
	endfunction

	// Send one pin transaction and record its expected read-back
	task automatic send_pin_access(input logic req, input logic [7:0] pin);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		pin_byte <= pin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pin_readback_q.push_back(eeprom_pin_step(req, pin));
		items_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic idle_inputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pin_readback_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the station MAC while the block is idle
	task automatic write_station_mac(input logic [mwe_pkg::MAC_W-1:0] mac);
		idle_inputs();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mac;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		station_mac = mac;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Run one serial read: start bit and opcode, nine address clocks, data clocks,
	// then drop select. A broken frame gets a read, a program-clear clock or an
	// early select drop at a random clock.
	task automatic read_words_serial(input logic [8:0] addr_bits, input int nwords,
		input bit broken);
		logic [11:0] cmd;
		logic        bit_in;
		int          total;
		int          break_at;
		int          kind;
		int          k;
		cmd      = {3'b110, addr_bits};
		total    = 12 + 16*nwords;
		break_at = broken ? int'($urandom_range(total-1)) : -1;
		kind     = $urandom_range(2);
		for (k = 0; k < total; k++) begin
			bit_in = (k < 12) ? cmd[11-k] : 1'($urandom_range(1));
			if (k == break_at) begin
				if (kind == 0) begin
					send_pin_access(mwe_pkg::REQ_READ, 8'($urandom));
				end else if (kind == 1) begin
					send_pin_access(mwe_pkg::REQ_WRITE, make_pins(1'b1, 1'b1, 1'b0, bit_in));
					send_pin_access(mwe_pkg::REQ_WRITE, make_pins(1'b0, 1'b1, 1'b1, bit_in));
					continue;
				end else begin
					break;
				end
			end
			send_pin_access(mwe_pkg::REQ_WRITE, make_pins(1'b1, 1'b1, 1'b0, bit_in));
			send_pin_access(mwe_pkg::REQ_WRITE, make_pins(1'b1, 1'b1, 1'b1, bit_in));
		end
		send_pin_access(mwe_pkg::REQ_WRITE,
			make_pins(1'b1, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1))));
	endtask

	// Pin register behavior outside a serial frame
	task automatic test_pin_register();
		send_pin_access(mwe_pkg::REQ_READ, 8'hFF);   // read before any write
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h7F);  // program mode clear, stored as written
		send_pin_access(mwe_pkg::REQ_READ, 8'h00);
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h81);  // data-out kept without a clock edge
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h8E);  // edge with select high
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h00);
		send_pin_access(mwe_pkg::REQ_WRITE, 8'hFF);  // every bit set
		send_pin_access(mwe_pkg::REQ_READ, 8'h55);
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h80);
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h84);  // edge with select low clears the frame
		send_pin_access(mwe_pkg::REQ_WRITE, 8'h00);
		send_pin_access(mwe_pkg::REQ_READ, 8'hAA);
	endtask

	// ID word and MAC words at both register extremes
	task automatic test_station_mac();
		write_station_mac({mwe_pkg::MAC_W{1'b1}});
		read_words_serial({1'b0, mwe_pkg::ADDR_MAC0}, 3, 1'b0);
		write_station_mac('0);
		read_words_serial({1'b0, mwe_pkg::ADDR_MAC0}, 3, 1'b0);
		read_words_serial({1'b0, mwe_pkg::ADDR_ID}, 1, 1'b0);
	endtask

	// Shifted address keeps low bits; auto-increment wraps past the top
	task automatic test_address_wrap();
		write_station_mac(48'h0123_4567_89AB);
		read_words_serial(9'h1FF, 2, 1'b0);
		read_words_serial({1'b1, mwe_pkg::ADDR_MAC2}, 1, 1'b0);
	endtask

	// Mostly well-formed reads with random content, the rest noise
	task automatic test_random_traffic(input int target);
		logic [8:0] addr_bits;
		int         nwords;
		int         stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 75) begin
				case ($urandom_range(5))
					0: addr_bits = {1'($urandom_range(1)), mwe_pkg::ADDR_ID};
					1: addr_bits = {1'($urandom_range(1)), 8'($urandom_range(6, 10))};
					2: addr_bits = {1'($urandom_range(1)), 8'($urandom_range(250, 255))};
					default: addr_bits = 9'($urandom);
				endcase
				nwords = ($urandom_range(99) < 70) ? 1 : int'($urandom_range(2, 4));
				read_words_serial(addr_bits, nwords, $urandom_range(99) < 20);
			end else begin
				repeat ($urandom_range(1, 8))
					send_pin_access(1'($urandom_range(1)), 8'($urandom));
			end
		end
	endtask

	// Compare each returned pin byte with the oldest expectation
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pin_readback_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: pins_out %02h", pins_out);
			end else begin
				want = pin_readback_q.pop_front();
				if (pins_out !== want) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: pins_out expected %02h got %02h", want, pins_out);
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = mwe_pkg::REQ_WRITE;
		pin_byte  = 8'h00;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		send_idle_pct = 28;
		recv_idle_pct = 47;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pin_register();
		test_station_mac();
		test_address_wrap();

		// Sweep idling: receiver-heavy, sender-heavy, then none
		write_station_mac(48'({$urandom, $urandom}));
		test_random_traffic(95);
		send_idle_pct = 47;
		recv_idle_pct = 28;
		write_station_mac(48'({$urandom, $urandom}));
		test_random_traffic(95);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_station_mac(48'({$urandom, $urandom}));
		test_random_traffic(95);

		idle_inputs();
		if (error_count == 0 && pin_readback_q.size() == 0) begin
			$display("microwire_eeprom_read_slave regression: pass");
		end else begin
			$display("microwire_eeprom_read_slave regression: fail");
		end
		$finish;
	end

endmodule
